// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the write extent coalescer.
// Depends on nothing; expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define CLWEC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked property that also looks at the reset cycles.
`define CLWEC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== design/clwec_pkg.sv =====
// Shared constants, types and helpers of the cache line write extent coalescer.
// Depends on nothing; imported by every module of the block.
package clwec_pkg;

    localparam int ADDRESS_BITS_DEF = 48;
    localparam int LENGTH_BITS_DEF  = 25;

    localparam int LOG2_BITS      = 5;
    localparam int LINE_LOG2_MIN  = 12;
    localparam int LINE_LOG2_MAX  = 16;
    localparam int LSIZE_BITS     = LINE_LOG2_MAX + 1;
    localparam int OFFSET_BITS    = LINE_LOG2_MAX;
    localparam int INDEX_BITS     = 32;
    localparam int BUF_BITS       = 32;
    localparam int POS_BITS       = BUF_BITS + 1;
    localparam int OUTQ_DEPTH     = 4;

    typedef enum logic {
        CFG_LINE_SIZE_LOG2 = 1'b0,
        CFG_DATA_AREA_BASE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic first;
        logic last;
        logic hit;
        logic seq;
    } t_line_flags;

    // Limit a written line size to the supported range.
    function automatic logic [LOG2_BITS-1:0] clamp_log2(input logic [LOG2_BITS-1:0] v);
        logic [LOG2_BITS-1:0] r;
        if (v < LOG2_BITS'(LINE_LOG2_MIN)) begin
            r = LOG2_BITS'(LINE_LOG2_MIN);
        end else if (v > LOG2_BITS'(LINE_LOG2_MAX)) begin
            r = LOG2_BITS'(LINE_LOG2_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/clwec_prep.sv =====
// Input register of the coalescer: line address arithmetic done on the way in.
// Depends on clwec_pkg.
module clwec_prep import clwec_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [LOG2_BITS-1:0]      i_line_log2,
    input  logic [ADDRESS_BITS-1:0]   i_data_base,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_first_line,
    input  logic                      i_last_line,
    input  logic                      i_sequential,
    input  logic [ADDRESS_BITS-1:0]   i_request_address,
    input  logic [LENGTH_BITS-1:0]    i_request_length,
    input  logic [BUF_BITS-1:0]       i_buffer_base,
    input  logic [INDEX_BITS-1:0]     i_cache_line_index,
    input  logic                      i_line_hit,
    input  logic                      i_take,
    output logic                      o_valid,
    output t_line_flags               o_flags,
    output logic [ADDRESS_BITS:0]     o_line_addr,
    output logic [ADDRESS_BITS:0]     o_run_addr,
    output logic [ADDRESS_BITS:0]     o_line_end,
    output logic [LENGTH_BITS-1:0]    o_head_len,
    output logic [LENGTH_BITS-1:0]    o_lsize,
    output logic [OFFSET_BITS-1:0]    o_skip,
    output logic [LENGTH_BITS-1:0]    o_req_length,
    output logic [BUF_BITS-1:0]       o_buffer_base
);

    localparam int DEV_BITS = ADDRESS_BITS + 1;

    logic                   r_valid;
    logic                   n_valid;
    t_line_flags            r_flags;
    logic [DEV_BITS-1:0]    r_line_addr;
    logic [DEV_BITS-1:0]    r_run_addr;
    logic [DEV_BITS-1:0]    r_line_end;
    logic [LENGTH_BITS-1:0] r_head_len;
    logic [LENGTH_BITS-1:0] r_lsize;
    logic [OFFSET_BITS-1:0] r_skip;
    logic [LENGTH_BITS-1:0] r_req_length;
    logic [BUF_BITS-1:0]    r_buffer_base;

    logic [LSIZE_BITS-1:0]  lsize;
    logic [OFFSET_BITS-1:0] lmask;
    logic [OFFSET_BITS-1:0] head_off;
    logic [OFFSET_BITS-1:0] end_low;
    logic [DEV_BITS-1:0]    idx_ext;
    logic [DEV_BITS-1:0]    idx_sh;
    logic [DEV_BITS-1:0]    idx_next_sh;
    logic [DEV_BITS-1:0]    base_ext;
    logic [DEV_BITS-1:0]    n_line_addr;
    logic [DEV_BITS-1:0]    n_run_addr;
    logic [DEV_BITS-1:0]    n_line_end;
    logic [LSIZE_BITS-1:0]  n_head_len;
    logic [OFFSET_BITS-1:0] n_skip;

    assign lsize    = LSIZE_BITS'(1) << i_line_log2;
    assign lmask    = lsize[OFFSET_BITS-1:0] - OFFSET_BITS'(1);
    assign head_off = i_first_line ? (i_request_address[OFFSET_BITS-1:0] & lmask) : '0;
    assign idx_ext  = DEV_BITS'(i_cache_line_index);
    assign idx_sh   = idx_ext << i_line_log2;
    assign idx_next_sh = (idx_ext + DEV_BITS'(1)) << i_line_log2;
    assign base_ext = DEV_BITS'(i_data_base);

    // Offset bits sit below the line boundary, so OR places them.
    assign n_line_addr = base_ext + idx_sh;
    assign n_run_addr  = base_ext + (idx_sh | DEV_BITS'(head_off));
    assign n_line_end  = base_ext + idx_next_sh;
    assign n_head_len  = lsize - LSIZE_BITS'(head_off);

    assign end_low = (i_request_address[OFFSET_BITS-1:0]
                      + i_request_length[OFFSET_BITS-1:0]) & lmask;
    assign n_skip  = (lsize[OFFSET_BITS-1:0] - end_low) & lmask;

    assign o_ready = !r_valid || i_take;
    assign n_valid = o_ready ? i_valid : 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_flags.first <= i_first_line;
            r_flags.last  <= i_last_line;
            r_flags.hit   <= i_line_hit;
            r_flags.seq   <= i_sequential;
            r_line_addr   <= n_line_addr;
            r_run_addr    <= n_run_addr;
            r_line_end    <= n_line_end;
            r_head_len    <= LENGTH_BITS'(n_head_len);
            r_lsize       <= LENGTH_BITS'(lsize);
            r_skip        <= n_skip;
            r_req_length  <= i_request_length;
            r_buffer_base <= i_buffer_base;
        end
    end

    assign o_valid       = r_valid;
    assign o_flags       = r_flags;
    assign o_line_addr   = r_line_addr;
    assign o_run_addr    = r_run_addr;
    assign o_line_end    = r_line_end;
    assign o_head_len    = r_head_len;
    assign o_lsize       = r_lsize;
    assign o_skip        = r_skip;
    assign o_req_length  = r_req_length;
    assign o_buffer_base = r_buffer_base;

endmodule

// ===== design/clwec_merge.sv =====
// Run tracking of the coalescer: merges contiguous lines and builds up to two extents.
// Depends on clwec_pkg; fed by clwec_prep, drains into clwec_outq.
module clwec_merge import clwec_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_room,
    input  t_line_flags               i_flags,
    input  logic [ADDRESS_BITS:0]     i_line_addr,
    input  logic [ADDRESS_BITS:0]     i_run_addr,
    input  logic [ADDRESS_BITS:0]     i_line_end,
    input  logic [LENGTH_BITS-1:0]    i_head_len,
    input  logic [LENGTH_BITS-1:0]    i_lsize,
    input  logic [OFFSET_BITS-1:0]    i_skip,
    input  logic [LENGTH_BITS-1:0]    i_req_length,
    input  logic [BUF_BITS-1:0]       i_buffer_base,
    output logic [1:0]                o_push,
    output logic [ADDRESS_BITS+LENGTH_BITS+POS_BITS+1:0] o_ext0,
    output logic [ADDRESS_BITS+LENGTH_BITS+POS_BITS+1:0] o_ext1
);

    localparam int DEV_BITS = ADDRESS_BITS + 1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic                   r_run_open;
    logic                   r_seq;
    logic [DEV_BITS-1:0]    r_run_start;
    logic [DEV_BITS-1:0]    r_run_end;
    logic [LENGTH_BITS-1:0] r_run_len;
    logic [LENGTH_BITS-1:0] r_bytes;
    logic [LENGTH_BITS-1:0] r_rem;
    logic [OFFSET_BITS-1:0] r_held_skip;
    logic [BUF_BITS-1:0]    r_held_bbase;

    logic                   n_run_open;
    logic                   n_seq;
    logic [DEV_BITS-1:0]    n_run_start;
    logic [DEV_BITS-1:0]    n_run_end;
    logic [LENGTH_BITS-1:0] n_run_len;
    logic [LENGTH_BITS-1:0] n_bytes;
    logic [LENGTH_BITS-1:0] n_rem;
    logic [OFFSET_BITS-1:0] n_held_skip;
    logic [BUF_BITS-1:0]    n_held_bbase;

    logic                   advance;
    logic                   first;
    logic                   open0;
    logic                   contig;
    logic [LENGTH_BITS:0]   ext_sum;
    logic [LENGTH_BITS-1:0] ext_len;
    logic [DEV_BITS-1:0]    ext_end;
    logic                   emit1;
    logic [LENGTH_BITS-1:0] len1;
    logic [POS_BITS-1:0]    pos1;
    logic [LENGTH_BITS-1:0] bytes_a;
    logic [LENGTH_BITS-1:0] rem_a;
    logic [LENGTH_BITS:0]   hit_sum;
    logic [LENGTH_BITS-1:0] bytes_hit;
    logic [LENGTH_BITS-1:0] rem_hit;
    logic                   open_after;
    logic [DEV_BITS-1:0]    start_after;
    logic [LENGTH_BITS-1:0] len_after;
    logic [DEV_BITS-1:0]    end_after;
    logic                   emit2;
    logic [LENGTH_BITS-1:0] skip_eff;
    logic [LENGTH_BITS-1:0] trim;
    logic [LENGTH_BITS-1:0] len2;
    logic [BUF_BITS-1:0]    bbase_eff;
    logic [POS_BITS-1:0]    pos2;
    logic [1:0]             push;

    assign advance = i_valid && i_room;
    assign first   = i_flags.first;
    assign open0   = !first && r_run_open;
    assign contig  = open0 && (i_line_addr == r_run_end);

    // Extend the open run by a whole line, saturating the length.
    assign ext_sum = {1'b0, r_run_len} + {1'b0, i_lsize};
    assign ext_len = ext_sum[LENGTH_BITS] ? LEN_MAX : ext_sum[LENGTH_BITS-1:0];
    assign ext_end = r_run_start + DEV_BITS'(ext_len);

    // Close the previous run; clamped to what is left, so bytes cannot overflow.
    assign emit1 = open0 && !contig;
    assign len1  = (r_run_len < r_rem) ? r_run_len : r_rem;
    assign pos1  = POS_BITS'(r_held_bbase) + POS_BITS'(r_bytes);

    assign bytes_a = first ? '0 : (emit1 ? (r_bytes + len1) : r_bytes);
    assign rem_a   = first ? i_req_length : (emit1 ? (r_rem - len1) : r_rem);

    // A hit at the head of a run is skipped but still consumes its bytes.
    assign hit_sum   = {1'b0, bytes_a} + {1'b0, i_head_len};
    assign bytes_hit = hit_sum[LENGTH_BITS] ? LEN_MAX : hit_sum[LENGTH_BITS-1:0];
    assign rem_hit   = (rem_a > i_head_len) ? (rem_a - i_head_len) : '0;

    assign open_after  = contig || !i_flags.hit;
    assign start_after = contig ? r_run_start : i_run_addr;
    assign len_after   = contig ? ext_len : i_head_len;
    assign end_after   = contig ? ext_end : i_line_end;

    // Last line: trim the tail and close the run.
    assign emit2     = i_flags.last && open_after;
    assign skip_eff  = LENGTH_BITS'(first ? i_skip : r_held_skip);
    assign trim      = (len_after > skip_eff) ? (len_after - skip_eff) : '0;
    assign len2      = (trim < rem_a) ? trim : rem_a;
    assign bbase_eff = first ? i_buffer_base : r_held_bbase;
    assign pos2      = POS_BITS'(bbase_eff) + POS_BITS'(bytes_a);

    always_comb begin
        n_run_open   = r_run_open;
        n_seq        = r_seq;
        n_run_start  = r_run_start;
        n_run_end    = r_run_end;
        n_run_len    = r_run_len;
        n_bytes      = r_bytes;
        n_rem        = r_rem;
        n_held_skip  = r_held_skip;
        n_held_bbase = r_held_bbase;
        push         = 2'd0;
        o_ext0       = {r_run_start, len1, pos1, !(emit1 && emit2)};
        o_ext1       = {start_after, len2, pos2, 1'b1};

        if (first) begin
            n_seq        = i_flags.seq;
            n_held_skip  = i_skip;
            n_held_bbase = i_buffer_base;
        end

        if (first && i_flags.seq) begin
            // Whole request as one write at the first line's position.
            n_run_open = 1'b0;
            n_bytes    = '0;
            n_rem      = i_req_length;
            push       = 2'd1;
            o_ext0     = {i_run_addr, i_req_length, POS_BITS'(i_buffer_base), 1'b1};
        end else if (first || !r_seq) begin
            n_run_open  = open_after && !emit2;
            n_run_start = start_after;
            n_run_len   = len_after;
            n_run_end   = end_after;
            if (!open_after) begin
                n_bytes = bytes_hit;
                n_rem   = rem_hit;
            end else if (emit2) begin
                n_bytes = bytes_a + len2;
                n_rem   = rem_a - len2;
            end else begin
                n_bytes = bytes_a;
                n_rem   = rem_a;
            end
            push = {1'b0, emit1} + {1'b0, emit2};
            if (!emit1) begin
                o_ext0 = {start_after, len2, pos2, 1'b1};
            end
        end
    end

    assign o_push = advance ? push : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open   <= 1'b0;
            r_seq        <= 1'b0;
            r_bytes      <= '0;
            r_rem        <= '0;
            r_held_skip  <= '0;
            r_held_bbase <= '0;
        end else if (advance) begin
            r_run_open   <= n_run_open;
            r_seq        <= n_seq;
            r_bytes      <= n_bytes;
            r_rem        <= n_rem;
            r_held_skip  <= n_held_skip;
            r_held_bbase <= n_held_bbase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_run_start <= n_run_start;
            r_run_end   <= n_run_end;
            r_run_len   <= n_run_len;
        end
    end

endmodule

// ===== design/clwec_outq.sv =====
// Result queue of the coalescer: takes up to two extents a cycle, gives one.
// Depends on clwec_pkg.
module clwec_outq import clwec_pkg::*; #(
    parameter int WIDTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push,
    input  logic [WIDTH-1:0] i_ext0,
    input  logic [WIDTH-1:0] i_ext1,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = $clog2(OUTQ_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    logic [WIDTH-1:0]    r_mem [OUTQ_DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] n_wr;
    logic [PTR_BITS-1:0] n_rd;
    logic [CNT_BITS-1:0] n_count;
    logic [PTR_BITS-1:0] wr_next;
    logic                pop;

    assign pop     = (r_count != '0) && i_ready;
    assign wr_next = r_wr + PTR_BITS'(1);
    assign n_wr    = r_wr + PTR_BITS'(i_push);
    assign n_rd    = r_rd + PTR_BITS'(pop);
    assign n_count = r_count + CNT_BITS'(i_push) - CNT_BITS'(pop);

    // Room for a worst-case pair of extents.
    assign o_room  = r_count <= CNT_BITS'(OUTQ_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_ext0;
        end
        if (i_push == 2'd2) begin
            r_mem[wr_next] <= i_ext1;
        end
    end

endmodule

// ===== design/cache_line_write_extent_coalescer.sv =====
// Channel   | handshake                 | item
// ----------+---------------------------+-------------------------------------------
// line in   | i_valid / o_ready         | one mapped cache line of a request
// extent    | o_valid / i_ready         | one device write extent (addr, len, pos)
// config    | i_cfg_valid / o_cfg_ready | register index and write data
//
// One line item is taken per cycle while o_ready is high; its extents pass through the
// input register and the result queue. A line item gives zero, one or two extents.
// The input register and the four-entry result queue set the rate: o_ready drops only
// while the queue holds more than two extents and the input register is full.
// Synchronous active-low reset empties both stages and clears the run state.
// Configuration writes are always taken (o_cfg_ready is tied high).
//
// Top level of the cache line write extent coalescer. Depends on clwec_pkg,
// clwec_prep, clwec_merge and clwec_outq.
module cache_line_write_extent_coalescer import clwec_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [ADDRESS_BITS-1:0] i_cfg_data,
    // line items
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_first_line,
    input  logic                    i_last_line,
    input  logic                    i_sequential,
    input  logic [ADDRESS_BITS-1:0] i_request_address,
    input  logic [LENGTH_BITS-1:0]  i_request_length,
    input  logic [BUF_BITS-1:0]     i_buffer_base,
    input  logic [INDEX_BITS-1:0]   i_cache_line_index,
    input  logic                    i_line_hit,
    // extent items
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [ADDRESS_BITS:0]   o_device_address,
    output logic [LENGTH_BITS-1:0]  o_write_length,
    output logic [POS_BITS-1:0]     o_buffer_position,
    output logic                    o_end_of_run
);

    localparam int DEV_BITS = ADDRESS_BITS + 1;
    localparam int EXT_BITS = DEV_BITS + LENGTH_BITS + POS_BITS + 1;

    // Configuration registers; the line size is held already clamped.
    logic [LOG2_BITS-1:0]    r_line_log2;
    logic [ADDRESS_BITS-1:0] r_data_base;

    // Input register to run logic.
    logic                   s1_valid;
    t_line_flags            s1_flags;
    logic [DEV_BITS-1:0]    s1_line_addr;
    logic [DEV_BITS-1:0]    s1_run_addr;
    logic [DEV_BITS-1:0]    s1_line_end;
    logic [LENGTH_BITS-1:0] s1_head_len;
    logic [LENGTH_BITS-1:0] s1_lsize;
    logic [OFFSET_BITS-1:0] s1_skip;
    logic [LENGTH_BITS-1:0] s1_req_length;
    logic [BUF_BITS-1:0]    s1_buffer_base;

    // Run logic to result queue.
    logic [1:0]             q_push;
    logic [EXT_BITS-1:0]    q_ext0;
    logic [EXT_BITS-1:0]    q_ext1;
    logic                   q_room;
    logic [EXT_BITS-1:0]    q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_log2 <= LOG2_BITS'(LINE_LOG2_MIN);
            r_data_base <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_SIZE_LOG2: r_line_log2 <= clamp_log2(i_cfg_data[LOG2_BITS-1:0]);
                CFG_DATA_AREA_BASE: r_data_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Register the line and work out its device addresses on the way in.
    clwec_prep #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_prep (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_line_log2        (r_line_log2),
        .i_data_base        (r_data_base),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_first_line       (i_first_line),
        .i_last_line        (i_last_line),
        .i_sequential       (i_sequential),
        .i_request_address  (i_request_address),
        .i_request_length   (i_request_length),
        .i_buffer_base      (i_buffer_base),
        .i_cache_line_index (i_cache_line_index),
        .i_line_hit         (i_line_hit),
        .i_take             (q_room),
        .o_valid            (s1_valid),
        .o_flags            (s1_flags),
        .o_line_addr        (s1_line_addr),
        .o_run_addr         (s1_run_addr),
        .o_line_end         (s1_line_end),
        .o_head_len         (s1_head_len),
        .o_lsize            (s1_lsize),
        .o_skip             (s1_skip),
        .o_req_length       (s1_req_length),
        .o_buffer_base      (s1_buffer_base)
    );

    // Merge contiguous lines into runs; close a run on a break or on the last line.
    clwec_merge #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s1_valid),
        .i_room        (q_room),
        .i_flags       (s1_flags),
        .i_line_addr   (s1_line_addr),
        .i_run_addr    (s1_run_addr),
        .i_line_end    (s1_line_end),
        .i_head_len    (s1_head_len),
        .i_lsize       (s1_lsize),
        .i_skip        (s1_skip),
        .i_req_length  (s1_req_length),
        .i_buffer_base (s1_buffer_base),
        .o_push        (q_push),
        .o_ext0        (q_ext0),
        .o_ext1        (q_ext1)
    );

    // Hold finished extents until the consumer takes them.
    clwec_outq #(
        .WIDTH (EXT_BITS)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ext0  (q_ext0),
        .i_ext1  (q_ext1),
        .o_room  (q_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (q_data)
    );

    assign o_device_address  = q_data[EXT_BITS-1 -: DEV_BITS];
    assign o_write_length    = q_data[POS_BITS+1 +: LENGTH_BITS];
    assign o_buffer_position = q_data[1 +: POS_BITS];
    assign o_end_of_run      = q_data[0];

endmodule

// ===== design/clwec_checker.sv =====
// Port-level checks of the cache line write extent coalescer, bound to the top level.
// Depends on clwec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clwec_checker import clwec_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_ready,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic [ADDRESS_BITS:0]   o_device_address,
    input logic [LENGTH_BITS-1:0]  o_write_length,
    input logic [POS_BITS-1:0]     o_buffer_position,
    input logic                    o_end_of_run
);

    // Reset empties both stages: nothing to show, room for an item.
    `CLWEC_ASSERT_RST(a_reset_empties, !i_rst_n |=> (!o_valid && o_ready), "not empty after reset")

    // With no extent waiting the queue has room, so the input must not stall.
    `CLWEC_ASSERT(a_idle_ready, !o_valid |-> o_ready, "input stalled with empty queue")

    // Both extents of one line are queued together; the second follows at once.
    `CLWEC_ASSERT(a_pair_follows, (o_valid && i_ready && !o_end_of_run) |=> o_valid, "second extent missing")

    // A stalled extent stays put.
    `CLWEC_ASSERT(a_out_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_device_address) && $stable(o_write_length) && $stable(o_buffer_position) && $stable(o_end_of_run)), "stalled extent changed")

endmodule

bind cache_line_write_extent_coalescer clwec_checker #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
) u_clwec_checker (.*);

// ===== dv/cache_line_write_extent_coalescer_tb.sv =====
// Self-checking testbench for the cache line write extent coalescer.
// Depends on clwec_pkg and the cache_line_write_extent_coalescer top level only.
module cache_line_write_extent_coalescer_tb import clwec_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = ADDRESS_BITS_DEF;
    localparam int LW = LENGTH_BITS_DEF;

    // One mapped line as the sender presents it.
    typedef struct packed {
        bit            first;
        bit            last;
        bit            seq;
        bit [AW-1:0]   addr;
        bit [LW-1:0]   req_len;
        bit [31:0]     buf_base;
        bit [31:0]     idx;
        bit            hit;
    } line_t;

    // One device write extent.
    typedef struct packed {
        bit [AW:0]       dev_addr;
        bit [LW-1:0]     wr_len;
        bit [POS_BITS-1:0] buf_pos;
        bit              eor;
    } ext_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_index = 1'b0;
    logic [AW-1:0]         i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_first_line = 1'b0;
    logic                  i_last_line = 1'b0;
    logic                  i_sequential = 1'b0;
    logic [AW-1:0]         i_request_address = '0;
    logic [LW-1:0]         i_request_length = '0;
    logic [BUF_BITS-1:0]   i_buffer_base = '0;
    logic [INDEX_BITS-1:0] i_cache_line_index = '0;
    logic                  i_line_hit = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [AW:0]           o_device_address;
    logic [LW-1:0]         o_write_length;
    logic [POS_BITS-1:0]   o_buffer_position;
    logic                  o_end_of_run;

    cache_line_write_extent_coalescer #(
        .ADDRESS_BITS(AW),
        .LENGTH_BITS (LW)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_first_line      (i_first_line),
        .i_last_line       (i_last_line),
        .i_sequential      (i_sequential),
        .i_request_address (i_request_address),
        .i_request_length  (i_request_length),
        .i_buffer_base     (i_buffer_base),
        .i_cache_line_index(i_cache_line_index),
        .i_line_hit        (i_line_hit),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_device_address  (o_device_address),
        .o_write_length    (o_write_length),
        .o_buffer_position (o_buffer_position),
        .o_end_of_run      (o_end_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Lines waiting to go out, the line on the ports, extents still owed.
    line_t lines_pending[$];
    line_t line_now;
    ext_t  extents_due[$];

    // Local copy of the registers, tracked at the edge where each write lands.
    bit [LOG2_BITS-1:0] cfg_log2 = 5'd12;
    bit [AW-1:0]        cfg_base = '0;

    // Coalescer state as the predictor sees it.
    bit            run_open;
    bit [AW:0]     run_addr;
    bit [LW-1:0]   run_len;
    bit [LW-1:0]   done_bytes;
    bit [15:0]     hold_addr_lo;
    bit [LW-1:0]   hold_len;
    bit [31:0]     hold_buf;
    bit            seq_mode;

    bit no_gaps = 1'b0;
    int lines_taken, extents_seen, mismatches, useful_lines, settings_seen;

    function automatic int line_shift();
        if (cfg_log2 < LINE_LOG2_MIN) return LINE_LOG2_MIN;
        if (cfg_log2 > LINE_LOG2_MAX) return LINE_LOG2_MAX;
        return int'(cfg_log2);
    endfunction

    function automatic bit [LW-1:0] sat_len(input bit [LW-1:0] x, input bit [LW-1:0] y);
        bit [LW:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[LW] ? '1 : s[LW-1:0];
    endfunction

    // Write out the open run, clamped to the bytes the request still has.
    task automatic close_run(input bit [LW-1:0] len);
        bit [LW-1:0] left;
        ext_t        e;
        left = (hold_len > done_bytes) ? hold_len - done_bytes : '0;
        if (len > left) len = left;
        e.dev_addr = run_addr;
        e.wr_len   = len;
        e.buf_pos  = POS_BITS'(hold_buf) + POS_BITS'(done_bytes);
        e.eor      = 1'b0;
        extents_due.push_back(e);
        done_bytes = sat_len(done_bytes, len);
        run_open   = 1'b0;
    endtask

    // Work out the extents one accepted line causes and queue them.
    task automatic predict_extents(input line_t ln);
        int          lg, made;
        bit [16:0]   lsz;
        bit [15:0]   lmask, off;
        bit [AW:0]   line_addr, a;
        bit [LW-1:0] b, endlow, skip, tail_len;
        ext_t        e;
        lg        = line_shift();
        lsz       = 17'd1 << lg;
        lmask     = 16'(lsz - 17'd1);
        line_addr = (AW+1)'(cfg_base) + ((AW+1)'(ln.idx) << lg);
        a         = line_addr;
        b         = LW'(lsz);
        made      = 0;
        if (ln.first) begin
            hold_addr_lo = ln.addr[15:0];
            hold_len     = ln.req_len;
            hold_buf     = ln.buf_base;
            seq_mode     = ln.seq;
            run_open     = 1'b0;
            run_len      = '0;
            done_bytes   = '0;
            off          = hold_addr_lo & lmask;
            if (seq_mode) begin
                // Whole request in one write at the first line's position.
                e.dev_addr = line_addr + (AW+1)'(off);
                e.wr_len   = hold_len;
                e.buf_pos  = POS_BITS'(hold_buf);
                e.eor      = 1'b1;
                extents_due.push_back(e);
                return;
            end
            a = line_addr + (AW+1)'(off);
            b = LW'(lsz) - LW'(off);
        end else if (seq_mode) begin
            return;
        end

        if (run_open && line_addr == run_addr + (AW+1)'(run_len)) begin
            run_len = sat_len(run_len, LW'(lsz));
        end else begin
            if (run_open) begin
                close_run(run_len);
                made++;
            end
            if (ln.hit) begin
                done_bytes = sat_len(done_bytes, b);
            end else begin
                run_open = 1'b1;
                run_addr = a;
                run_len  = b;
            end
        end

        if (ln.last && run_open) begin
            // Trim the tail of the last line.
            endlow   = (LW'(hold_addr_lo) + hold_len) & LW'(lmask);
            skip     = (LW'(lsz) - endlow) & LW'(lmask);
            tail_len = (run_len > skip) ? run_len - skip : '0;
            close_run(tail_len);
            made++;
        end

        if (made > 0) begin
            e = extents_due.pop_back();
            e.eor = 1'b1;
            extents_due.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Sender: hold the item until taken, predict on the accepting edge, then
    // advance or idle at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_extents(line_now);
                lines_taken++;
            end
            if (!i_valid || o_ready) begin
                if (lines_pending.size() != 0 && (no_gaps || $urandom_range(99) >= 30)) begin
                    line_now           = lines_pending.pop_front();
                    i_valid            <= 1'b1;
                    i_first_line       <= line_now.first;
                    i_last_line        <= line_now.last;
                    i_sequential       <= line_now.seq;
                    i_request_address  <= line_now.addr;
                    i_request_length   <= line_now.req_len;
                    i_buffer_base      <= line_now.buf_base;
                    i_cache_line_index <= line_now.idx;
                    i_line_hit         <= line_now.hit;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each taken extent against the oldest one owed, and
    // stall at random.
    always @(posedge i_clk) begin
        ext_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                extents_seen++;
                if (extents_due.size() == 0) begin
                    report_mismatch("extent with none owed", 64'(o_device_address), 64'h0);
                end else begin
                    want = extents_due.pop_front();
                    if (o_device_address !== want.dev_addr)
                        report_mismatch("device_address", 64'(o_device_address),
                                        64'(want.dev_addr));
                    if (o_write_length !== want.wr_len)
                        report_mismatch("write_length", 64'(o_write_length), 64'(want.wr_len));
                    if (o_buffer_position !== want.buf_pos)
                        report_mismatch("buffer_position", 64'(o_buffer_position),
                                        64'(want.buf_pos));
                    if (o_end_of_run !== want.eor)
                        report_mismatch("end_of_run", 64'(o_end_of_run), 64'(want.eor));
                end
            end
            i_ready <= no_gaps || ($urandom_range(99) >= 30);
        end
    end

    task automatic put_line(input bit first, input bit last, input bit seq,
                            input bit [AW-1:0] addr, input bit [LW-1:0] len,
                            input bit [31:0] bufb, input bit [31:0] idx, input bit hit);
        line_t ln;
        ln.first    = first;
        ln.last     = last;
        ln.seq      = seq;
        ln.addr     = addr;
        ln.req_len  = len;
        ln.buf_base = bufb;
        ln.idx      = idx;
        ln.hit      = hit;
        lines_pending.push_back(ln);
    endtask

    // Request fields on lines other than the first are ignored; fill them anyway.
    function automatic line_t scatter_request(input line_t ln);
        ln.seq      = 1'($urandom_range(1));
        ln.addr     = AW'({$urandom, $urandom});
        ln.req_len  = LW'($urandom_range(32'h100_0000, 1));
        ln.buf_base = $urandom;
        ln.hit      = ($urandom_range(99) < 25);
        return ln;
    endfunction

    // Mostly the next line, sometimes a repeat, a jump or a fresh index.
    function automatic bit [31:0] next_index(input bit [31:0] idx);
        int r;
        r = $urandom_range(99);
        if (r < 70) return idx + 32'd1;
        if (r < 78) return idx;
        if (r < 90) return idx + $urandom_range(8, 2);
        return $urandom;
    endfunction

    // Queue one request: usually well formed, at times cut short, left open,
    // or trailed by stray lines that carry on with the held values.
    task automatic add_request(input int lg);
        line_t       ln;
        int          n, r, k, off;
        int unsigned lsz;
        bit          seq_req, open_end;
        lsz         = 1 << lg;
        ln.first    = 1'b1;
        ln.last     = 1'b0;
        seq_req     = ($urandom_range(99) < 15);
        ln.seq      = seq_req;
        ln.addr     = AW'({$urandom, $urandom});
        r = $urandom_range(9);
        if (r == 0) ln.addr = ln.addr & ~AW'(lsz - 1);
        else if (r == 1) ln.addr = ln.addr | AW'(lsz - 1);
        r = $urandom_range(99);
        if (r < 4) ln.req_len = LW'(32'h100_0000);
        else if (r < 10) ln.req_len = LW'($urandom_range(32'h100_0000, 1));
        else if (r < 25) ln.req_len = LW'($urandom_range(64, 1));
        else ln.req_len = LW'($urandom_range(6 * lsz, 1));
        r = $urandom_range(19);
        ln.buf_base = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        r = $urandom_range(19);
        ln.idx = (r < 2) ? 32'hFFFF_FFFF - $urandom_range(3) : (r == 2) ? 32'h0 : $urandom;
        ln.hit = ($urandom_range(99) < 25);

        off = int'(ln.addr[15:0]) & int'(lsz - 1);
        n = ((off + int'(ln.req_len) - 1) >> lg) + 1;
        if (n > 12) n = $urandom_range(12, 2);
        if (seq_req) n = $urandom_range(3, 1);
        r = $urandom_range(99);
        open_end = (r < 8);
        if (r >= 8 && r < 14) n = $urandom_range(n, 1);

        for (k = 0; k < n; k++) begin
            ln.last = (k == n - 1) && !open_end;
            lines_pending.push_back(ln);
            if (!seq_req || k == 0) useful_lines++;
            ln       = scatter_request(ln);
            ln.first = 1'b0;
            ln.idx   = next_index(ln.idx);
        end

        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(3, 1)) begin
                ln.last = 1'($urandom_range(1));
                lines_pending.push_back(ln);
                if (!seq_req) useful_lines++;
                ln     = scatter_request(ln);
                ln.idx = next_index(ln.idx);
            end
        end
    endtask

    task automatic write_reg(input t_cfg_reg which, input bit [AW-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (which == CFG_LINE_SIZE_LOG2) cfg_log2 = val[LOG2_BITS-1:0];
        else cfg_base = val;
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for the sender to drain and every owed extent to land, then let
    // the pipeline settle in case the last lines produced nothing.
    task automatic wait_quiet();
        @(negedge i_clk);
        while (lines_pending.size() != 0 || i_valid || extents_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        line_t              ln;
        int                 p, k, goal;
        bit [LOG2_BITS-1:0] lg_val;
        bit [AW-1:0]        base_val;
        bit [31:0]          idx0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settings_seen = 1;

        // Directed lines under the reset settings (4 KiB lines, base zero).
        // Sequential request at the field extremes, then a line it ignores.
        put_line(1, 0, 1, 48'hFFFF_FFFF_FFFF, 25'h100_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        put_line(0, 1, 0, 48'h0, 25'h1, 32'h0, 32'd5, 0);
        // Single line trimmed at both ends; then the same as a hit, which writes nothing.
        put_line(1, 1, 0, 48'h123, 25'h100, 32'h0, 32'h0, 0);
        put_line(1, 1, 0, 48'h123, 25'h100, 32'h10, 32'd7, 1);
        // Three contiguous misses merged into one extent.
        put_line(1, 0, 0, 48'h800, 25'h2000, 32'h1000, 32'd10, 0);
        put_line(0, 0, 0, 48'h0, 25'h1, 32'h0, 32'd11, 0);
        put_line(0, 1, 0, 48'h0, 25'h1, 32'h0, 32'd12, 0);
        // Hit inside a run merges; a break closes the run.
        put_line(1, 0, 0, 48'h0, 25'h4000, 32'h2000, 32'd20, 0);
        put_line(0, 0, 0, 48'h0, 25'h1, 32'h0, 32'd21, 1);
        put_line(0, 0, 0, 48'h0, 25'h1, 32'h0, 32'd40, 0);
        put_line(0, 1, 0, 48'h0, 25'h1, 32'h0, 32'd41, 0);
        // Break on the last line: two extents from one item.
        put_line(1, 0, 0, 48'h0, 25'h2000, 32'h3000, 32'd50, 0);
        put_line(0, 1, 0, 48'h0, 25'h1, 32'h0, 32'd60, 0);
        // A hit that would start a run is skipped.
        put_line(1, 0, 0, 48'h10, 25'h3000, 32'h4000, 32'd70, 0);
        put_line(0, 0, 0, 48'h0, 25'h1, 32'h0, 32'd80, 1);
        put_line(0, 1, 0, 48'h0, 25'h1, 32'h0, 32'd81, 0);
        // Request left open, dropped by the next first line.
        put_line(1, 0, 0, 48'h0, 25'h3000, 32'h5000, 32'd90, 0);
        put_line(1, 1, 0, 48'hFFF, 25'h1, 32'h6000, 32'd95, 0);
        // Line with no first line after a finished request: bytes exhausted.
        put_line(0, 1, 0, 48'h0, 25'h1, 32'h0, 32'd100, 0);
        // Tail longer than the trimmed run.
        put_line(1, 1, 0, 48'hF00, 25'h180, 32'h7000, 32'd110, 0);
        // Last byte of a line as the start, longest length, top index.
        put_line(1, 1, 0, 48'hFFF, 25'h100_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        // Smallest sequential request.
        put_line(1, 1, 1, 48'h0, 25'h1, 32'h0, 32'h0, 0);
        wait_quiet();

        // Random phases, one register setting each; settle before every write.
        goal = 0;
        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin lg_val = 5'd16; base_val = '1; end
                1: begin lg_val = 5'd13; base_val = AW'({$urandom, $urandom}); end
                2: begin lg_val = 5'd0;  base_val = '0; end
                3: begin lg_val = 5'd31; base_val = AW'({$urandom, $urandom}); end
                4: begin lg_val = 5'd14; base_val = AW'({$urandom, $urandom}); end
                5: begin lg_val = 5'd15; base_val = AW'({$urandom, $urandom}); end
                6: begin lg_val = 5'd12; base_val = '1; end
                default: begin
                    lg_val   = LOG2_BITS'($urandom_range(31));
                    base_val = AW'({$urandom, $urandom});
                end
            endcase
            // Upper data bits of the line size write are ignored; fill them anyway.
            write_reg(CFG_LINE_SIZE_LOG2, {(AW-LOG2_BITS)'({$urandom, $urandom}), lg_val});
            write_reg(CFG_DATA_AREA_BASE, base_val);
            settings_seen++;
            no_gaps = (p == 4);
            goal += 106;
            while (useful_lines < goal) add_request(line_shift());

            if (p == 3) begin
                // One long request: enough hits to saturate the done count,
                // then a contiguous run long enough to saturate its length.
                ln          = '0;
                ln.first    = 1'b1;
                ln.addr     = AW'({$urandom, $urandom});
                ln.req_len  = LW'(32'h100_0000);
                ln.buf_base = $urandom;
                ln.idx      = $urandom;
                ln.hit      = 1'b1;
                lines_pending.push_back(ln);
                ln.first = 1'b0;
                for (k = 0; k < 520; k++) begin
                    ln.idx = $urandom;
                    lines_pending.push_back(ln);
                end
                idx0 = $urandom;
                for (k = 0; k < 520; k++) begin
                    ln.idx  = idx0 + k;
                    ln.hit  = (k != 0) && ($urandom_range(99) < 25);
                    ln.last = (k == 519);
                    lines_pending.push_back(ln);
                end
            end
            wait_quiet();
        end
        no_gaps = 1'b0;

        $display("Ran %0d line items under %0d register settings, %0d extents checked,",
                 lines_taken, settings_seen, extents_seen);
        $display("including sequential, merged, trimmed, saturated and open-ended requests.");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
